[sv/histogram_equalizer_defines.svh]
// ---------------------------------------------------------------------------
// histogram_equalizer_defines
// Assertion macros for the histogram equaliser RTL. They expect clk and
// rst_n to be visible where they are used.
// ---------------------------------------------------------------------------
`ifndef HISTOGRAM_EQUALIZER_DEFINES_SVH
`define HISTOGRAM_EQUALIZER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define HISTEQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HISTEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/histeq_pkg.sv]
// ---------------------------------------------------------------------------
// histeq_pkg
// Types, constants and the lane control bundle of the histogram equaliser.
// ---------------------------------------------------------------------------
package histeq_pkg;

  localparam int COUNT_BITS    = 24;
  localparam int BINS          = 256;
  localparam int BIN_BITS      = $clog2(BINS);
  localparam int IDX_BITS      = BIN_BITS + 1;
  localparam int QUOT_BITS     = 8;
  localparam int STEP_BITS     = $clog2(QUOT_BITS + 1);
  localparam int QIDX_BITS     = $clog2(QUOT_BITS);
  localparam int REM_BITS      = COUNT_BITS + QUOT_BITS;
  localparam int LUMA_SUM_BITS = BIN_BITS + 5;
  localparam int LANES         = 4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [QUOT_BITS-1:0]  OUT_MAX   = '1;

  localparam int LANE_R = 0;
  localparam int LANE_G = 1;
  localparam int LANE_B = 2;
  localparam int LANE_L = 3;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_BUILD = 2'd2,
    CMD_MAP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_ACC,
    ST_MAP_RD,
    ST_MAP_LD,
    ST_MAP_DIV
  } state_t;

  typedef struct packed {
    logic                clear;
    logic [BIN_BITS-1:0] rd_addr;
    logic                wr_en;
    logic [BIN_BITS-1:0] wr_addr;
    logic                acc_mode;
    logic                acc_first;
    logic                div_start;
  } lane_ctl_t;

endpackage

[sv/histogram_equalizer.sv]
// ---------------------------------------------------------------------------
// histogram_equalizer
// Histogram equaliser for 8-bit RGB pixels with red, green, blue and
// luminance lanes, a sequencer and an output merge stage.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries a command and one pixel. One
//   transaction is in work at a time; in_ready is high while the sequencer
//   is idle. Clear leaves the sequencer idle; count pixel reads the bins,
//   then writes them back; build cumulative tables makes one pass over the
//   256 bins of every lane through the RAM read and write ports; map pixel
//   does a RAM read, divider load, range check, eight quotient steps of the
//   lane divider and the output load, and skips the quotient steps when the
//   pixel total is zero or the quotient clips at 255.
//   Only map produces a result transaction on out_valid/out_ready. The
//   result is held in an output register, so a new command is accepted
//   while it waits. A map finishing while the previous result is still
//   stalled waits in its last state until the receiver takes it.
//   color_mode (APB, any paddr, reset 1): 1 gives per-channel mapping, 0
//   puts the mapped luminance on all three colour outputs.
//   Reset clears all bins through their valid flags at once, zeroes the
//   pixel total and needs no clearing pass.
// ---------------------------------------------------------------------------
`include "histogram_equalizer_defines.svh"

module histogram_equalizer
  import histeq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_pixel_red,
  input  logic [7:0]  in_pixel_green,
  input  logic [7:0]  in_pixel_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_gray,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t                state_r, state_nxt;
  logic [IDX_BITS-1:0]   idx_r, idx_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic                  color_mode_r;
  logic [BIN_BITS-1:0]   pix_r [LANES];
  logic [BIN_BITS-1:0]   pix_nxt [LANES];
  logic [LUMA_SUM_BITS-1:0] luma_sum;
  lane_ctl_t             lane_ctl [LANES];
  logic [LANES-1:0]      lane_busy;
  logic [QUOT_BITS-1:0]  lane_quot [LANES];
  logic                  accept;
  logic                  out_load;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_red_r, out_green_r, out_blue_r, out_gray_r;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign prdata = {31'b0, color_mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      color_mode_r <= pwdata[0];
    end
  end

  // luminance: (11r + 16g + 5b) / 32
  assign luma_sum = LUMA_SUM_BITS'(in_pixel_red)   * LUMA_SUM_BITS'(11)
                  + LUMA_SUM_BITS'(in_pixel_green) * LUMA_SUM_BITS'(16)
                  + LUMA_SUM_BITS'(in_pixel_blue)  * LUMA_SUM_BITS'(5);

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // ------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    total_nxt = total_r;
    out_load  = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      pix_nxt[i] = pix_r[i];
    end
    if (accept) begin
      pix_nxt[LANE_R] = in_pixel_red;
      pix_nxt[LANE_G] = in_pixel_green;
      pix_nxt[LANE_B] = in_pixel_blue;
      pix_nxt[LANE_L] = luma_sum[LUMA_SUM_BITS-1 -: BIN_BITS];
    end
    for (int i = 0; i < LANES; i++) begin
      lane_ctl[i].clear     = accept && (cmd_t'(in_cmd) == CMD_CLEAR);
      lane_ctl[i].rd_addr   = pix_r[i];
      lane_ctl[i].wr_en     = 1'b0;
      lane_ctl[i].wr_addr   = pix_r[i];
      lane_ctl[i].acc_mode  = 1'b0;
      lane_ctl[i].acc_first = 1'b0;
      lane_ctl[i].div_start = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(in_cmd))
            CMD_CLEAR: total_nxt = '0;
            CMD_COUNT: state_nxt = ST_CNT_RD;
            CMD_BUILD: begin
              idx_nxt   = '0;
              state_nxt = ST_ACC;
            end
            CMD_MAP:   state_nxt = ST_MAP_RD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CNT_RD: state_nxt = ST_CNT_WR;
      ST_CNT_WR: begin
        for (int i = 0; i < LANES; i++) begin
          lane_ctl[i].wr_en = 1'b1;
        end
        if (total_r != COUNT_MAX) begin
          total_nxt = total_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_ACC: begin
        // read bin idx while writing the running sum of bin idx-1
        for (int i = 0; i < LANES; i++) begin
          lane_ctl[i].rd_addr   = idx_r[BIN_BITS-1:0];
          lane_ctl[i].wr_addr   = idx_r[BIN_BITS-1:0] - 1'b1;
          lane_ctl[i].wr_en     = (idx_r != '0);
          lane_ctl[i].acc_mode  = 1'b1;
          lane_ctl[i].acc_first = (idx_r == IDX_BITS'(1));
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_BITS'(BINS)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MAP_RD: state_nxt = ST_MAP_LD;
      ST_MAP_LD: begin
        for (int i = 0; i < LANES; i++) begin
          lane_ctl[i].div_start = 1'b1;
        end
        state_nxt = ST_MAP_DIV;
      end
      ST_MAP_DIV: begin
        if ((lane_busy == '0) && (!out_valid_r || out_ready)) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      total_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      idx_r   <= idx_nxt;
    end
    for (int i = 0; i < LANES; i++) begin
      pix_r[i] <= pix_nxt[i];
    end
  end

  // ----------------------------------------------------------------- lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    histeq_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lane_ctl[g]),
      .total (total_r),
      .busy  (lane_busy[g]),
      .quot  (lane_quot[g])
    );
  end

  // ------------------------------------------------------------ merge stage
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_gray_r  <= lane_quot[LANE_L];
      out_red_r   <= color_mode_r ? lane_quot[LANE_R] : lane_quot[LANE_L];
      out_green_r <= color_mode_r ? lane_quot[LANE_G] : lane_quot[LANE_L];
      out_blue_r  <= color_mode_r ? lane_quot[LANE_B] : lane_quot[LANE_L];
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_gray  = out_gray_r;

  // ------------------------------------------------------------ assertions
  `HISTEQ_ASSERT_SAME(a_result_from_map, $rose(out_valid_r), $past(state_r == ST_MAP_DIV), "result transaction not produced by a map")
  `HISTEQ_ASSERT_NEXT(a_count_seq, accept && (cmd_t'(in_cmd) == CMD_COUNT), state_r == ST_CNT_RD, "count transaction did not start its read")
  `HISTEQ_ASSERT_NEXT(a_total_monotonic, state_r != ST_IDLE, total_r >= $past(total_r), "pixel total fell outside a clear")

endmodule

[sv/histeq_ram.sv]
// ---------------------------------------------------------------------------
// histeq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
module histeq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[sv/histeq_div.sv]
// ---------------------------------------------------------------------------
// histeq_div
// Restoring divider for floor(num*255/den), clipped at 255, zero for a zero
// denominator. One range check, then one quotient bit per cycle.
// ---------------------------------------------------------------------------
module histeq_div
  import histeq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] num,
  input  logic [COUNT_BITS-1:0] den,
  output logic                  busy,
  output logic [QUOT_BITS-1:0]  quot
);

  localparam logic [STEP_BITS-1:0] STEP_SAT = STEP_BITS'(QUOT_BITS);

  logic                 busy_r, busy_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic [REM_BITS-1:0]  rem_r, rem_nxt;
  logic [REM_BITS-1:0]  dsh_r, dsh_nxt;
  logic [QUOT_BITS-1:0] quot_r, quot_nxt;
  logic                 den_zero_r, den_zero_nxt;
  logic                 fits;

  assign fits = (rem_r >= dsh_r);

  always_comb begin
    busy_nxt     = busy_r;
    step_nxt     = step_r;
    rem_nxt      = rem_r;
    dsh_nxt      = dsh_r;
    quot_nxt     = quot_r;
    den_zero_nxt = den_zero_r;
    if (start) begin
      // num*255 as num*256 - num
      rem_nxt      = {num, QUOT_BITS'(0)} - {QUOT_BITS'(0), num};
      dsh_nxt      = {den, QUOT_BITS'(0)};
      den_zero_nxt = (den == '0);
      quot_nxt     = '0;
      step_nxt     = STEP_SAT;
      busy_nxt     = 1'b1;
    end else if (busy_r) begin
      if (step_r == STEP_SAT) begin
        if (den_zero_r) begin
          quot_nxt = '0;
          busy_nxt = 1'b0;
        end else if (fits) begin
          quot_nxt = OUT_MAX;
          busy_nxt = 1'b0;
        end else begin
          dsh_nxt  = dsh_r >> 1;
          step_nxt = step_r - 1'b1;
        end
      end else begin
        if (fits) begin
          rem_nxt                         = rem_r - dsh_r;
          quot_nxt[step_r[QIDX_BITS-1:0]] = 1'b1;
        end
        if (step_r == '0) begin
          busy_nxt = 1'b0;
        end else begin
          dsh_nxt  = dsh_r >> 1;
          step_nxt = step_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    rem_r      <= rem_nxt;
    dsh_r      <= dsh_nxt;
    quot_r     <= quot_nxt;
    den_zero_r <= den_zero_nxt;
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

[sv/histeq_lane.sv]
// ---------------------------------------------------------------------------
// histeq_lane
// One histogram lane: bin RAM with per-bin valid flags, saturating count and
// running-sum update, and its own mapping divider.
// ---------------------------------------------------------------------------
module histeq_lane
  import histeq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  lane_ctl_t             ctl,
  input  logic [COUNT_BITS-1:0] total,
  output logic                  busy,
  output logic [QUOT_BITS-1:0]  quot
);

  logic [BINS-1:0]       valid_r, valid_nxt;
  logic [BIN_BITS-1:0]   rd_addr_q_r;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] bin_val;
  logic [COUNT_BITS-1:0] inc_val;
  logic [COUNT_BITS-1:0] run_r, run_nxt;
  logic [COUNT_BITS-1:0] run_base;
  logic [COUNT_BITS:0]   acc_sum;
  logic [COUNT_BITS-1:0] acc_sat;
  logic [COUNT_BITS-1:0] wr_data;

  histeq_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BINS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (ctl.wr_addr),
    .wr_data (wr_data),
    .rd_addr (ctl.rd_addr),
    .rd_data (rd_data)
  );

  // a bin never written since the last clear reads as zero
  assign bin_val  = valid_r[rd_addr_q_r] ? rd_data : '0;
  assign inc_val  = (bin_val == COUNT_MAX) ? bin_val : bin_val + 1'b1;
  assign run_base = ctl.acc_first ? '0 : run_r;
  assign acc_sum  = {1'b0, run_base} + {1'b0, bin_val};
  assign acc_sat  = acc_sum[COUNT_BITS] ? COUNT_MAX : acc_sum[COUNT_BITS-1:0];
  assign wr_data  = ctl.acc_mode ? acc_sat : inc_val;

  always_comb begin
    valid_nxt = valid_r;
    run_nxt   = run_r;
    if (ctl.clear) begin
      valid_nxt = '0;
    end else if (ctl.wr_en) begin
      valid_nxt[ctl.wr_addr] = 1'b1;
    end
    if (ctl.wr_en && ctl.acc_mode) begin
      run_nxt = acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
    rd_addr_q_r <= ctl.rd_addr;
    run_r       <= run_nxt;
  end

  histeq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (bin_val),
    .den   (total),
    .busy  (busy),
    .quot  (quot)
  );

endmodule

[tb/histeq_tb_pkg.sv]
// ---------------------------------------------------------------------------
// histeq_tb_pkg
// Register map and mode codes shared by the histogram equaliser testbench.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package histeq_tb_pkg;

  typedef enum logic {
    MODE_GRAY = 1'b0,
    MODE_RGB  = 1'b1
  } color_mode_t;

  localparam logic [1:0] REG_COLOR_MODE = 2'd0;

endpackage

[tb/histeq_checker.sv]
// ---------------------------------------------------------------------------
// histeq_checker
// Watches the pixel, result and APB ports of the histogram equaliser, keeps
// its own copy of the histograms and pixel total, predicts each equalised
// pixel and compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module histeq_checker
  import histeq_pkg::*;
  import histeq_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_pixel_red,
  input  logic [7:0]  in_pixel_green,
  input  logic [7:0]  in_pixel_blue,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  out_gray,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  output int unsigned mismatches,
  output int unsigned pending
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] gray;
  } eq_pixel_t;

  logic [COUNT_BITS-1:0] hist [LANES][BINS];
  logic [COUNT_BITS-1:0] total;
  color_mode_t           mode;
  eq_pixel_t             awaited [$];
  int unsigned           fails;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    int s;
    s = 11 * r + 16 * g + 5 * b;
    return s[12:5];
  endfunction

  // floor(cum * 255 / total), pinned at 255 when the table runs past the total
  function automatic logic [7:0] equalize(input int lane, input logic [7:0] level);
    logic [63:0] cum;
    logic [63:0] den;
    logic [63:0] q;
    if (total == '0) return '0;
    cum = hist[lane][level];
    den = total;
    q   = (cum * 64'd255) / den;
    return (q > 64'd255) ? OUT_MAX : q[7:0];
  endfunction

  function automatic int unsigned field_bad(input string name, input logic [7:0] want,
                                            input logic [7:0] got);
    if (got === want) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  task automatic wipe();
    for (int ln = 0; ln < LANES; ln++)
      for (int bn = 0; bn < BINS; bn++)
        hist[ln][bn] = '0;
    total = '0;
  endtask

  always @(posedge clk) begin : track
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  l;
    logic [63:0] run;
    eq_pixel_t   want;
    if (!rst_n) begin
      wipe();
      mode = MODE_RGB;
      awaited.delete();
      fails = 0;
    end else begin
      if (psel && penable && pready && paddr == REG_COLOR_MODE) begin
        if (pwrite) begin
          mode = color_mode_t'(pwdata[0]);
        end else if (prdata[0] !== mode) begin
          $error("color_mode readback: expected %0d, got %0d", mode, prdata[0]);
          fails++;
        end
      end

      if (in_valid && in_ready) begin
        r = in_pixel_red;
        g = in_pixel_green;
        b = in_pixel_blue;
        l = luma_of(r, g, b);
        case (cmd_t'(in_cmd))
          CMD_CLEAR: wipe();
          CMD_COUNT: begin
            hist[LANE_R][r] = bump(hist[LANE_R][r]);
            hist[LANE_G][g] = bump(hist[LANE_G][g]);
            hist[LANE_B][b] = bump(hist[LANE_B][b]);
            hist[LANE_L][l] = bump(hist[LANE_L][l]);
            total = bump(total);
          end
          CMD_BUILD: begin
            // running sums clip at the counter ceiling
            for (int ln = 0; ln < LANES; ln++) begin
              run = '0;
              for (int bn = 0; bn < BINS; bn++) begin
                run = run + hist[ln][bn];
                if (run > COUNT_MAX) run = COUNT_MAX;
                hist[ln][bn] = run[COUNT_BITS-1:0];
              end
            end
          end
          default: begin
            want.gray = equalize(LANE_L, l);
            if (mode == MODE_RGB) begin
              want.red   = equalize(LANE_R, r);
              want.green = equalize(LANE_G, g);
              want.blue  = equalize(LANE_B, b);
            end else begin
              want.red   = want.gray;
              want.green = want.gray;
              want.blue  = want.gray;
            end
            awaited.push_back(want);
          end
        endcase
      end

      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("result transaction with no map command outstanding");
          fails++;
        end else begin
          want = awaited.pop_front();
          fails += field_bad("out_red", want.red, out_red);
          fails += field_bad("out_green", want.green, out_green);
          fails += field_bad("out_blue", want.blue, out_blue);
          fails += field_bad("out_gray", want.gray, out_gray);
        end
      end
    end
    mismatches <= fails;
    pending    <= awaited.size();
  end

endmodule

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Drives the histogram equaliser with directed and random command streams
// (clear, count, build, map) under random idling on both channels and in
// both colour modes; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import histeq_pkg::*;
  import histeq_tb_pkg::*;

  localparam int GAP_MAX       = 12;
  localparam int SETTLE_CYCLES = 300;   // longer than a full table build
  localparam int RANDOM_ITEMS  = 1950;
  localparam int PHASE_ITEMS   = 200;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 2_000_000;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd         = CMD_CLEAR;
  logic [7:0]  in_pixel_red   = '0;
  logic [7:0]  in_pixel_green = '0;
  logic [7:0]  in_pixel_blue  = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_gray;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [1:0]  paddr          = REG_COLOR_MODE;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned sent;
  bit          sender_quiet;

  histogram_equalizer dut (.*);

  histeq_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] pick_level();
    logic [7:0] v;
    case ($urandom_range(0, 7))
      0:       v = 8'h00;
      1:       v = 8'hFF;
      default: v = $urandom_range(0, 255);
    endcase
    return v;
  endfunction

  // valid is only dropped when a gap is drawn or the stream drains, so it
  // never falls and rises within one step
  task automatic send(input cmd_t c, input logic [7:0] r, input logic [7:0] g,
                      input logic [7:0] b);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= c;
    in_pixel_red   <= r;
    in_pixel_green <= g;
    in_pixel_blue  <= b;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_pixel(input cmd_t c);
    send(c, pick_level(), pick_level(), pick_level());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write, then read back so the checker can compare
  task automatic set_mode(input color_mode_t m);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= REG_COLOR_MODE;
    pwdata <= {31'b0, m};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // clear, count a frame, build (now and then several times), then map
  task automatic run_sequence();
    int unsigned pixels;
    int unsigned builds;
    int unsigned lookups;
    pixels  = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 200) : $urandom_range(1, 30);
    builds  = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 5) : 1;
    lookups = $urandom_range(1, 30);
    send_pixel(CMD_CLEAR);
    repeat (pixels) send_pixel(CMD_COUNT);
    repeat (builds) send_pixel(CMD_BUILD);
    repeat (lookups) send_pixel(CMD_MAP);
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 10)) send_pixel(cmd_t'($urandom_range(0, 3)));
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    sender_quiet = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero total straight after reset
    send(CMD_MAP, 8'd0, 8'd0, 8'd0);
    send(CMD_MAP, 8'd255, 8'd128, 8'd1);
    send(CMD_COUNT, 8'd0, 8'd0, 8'd0);
    send(CMD_COUNT, 8'd255, 8'd255, 8'd255);
    send(CMD_COUNT, 8'hAA, 8'h55, 8'h0F);
    // lookups on raw bins, before any build
    send(CMD_MAP, 8'd0, 8'd0, 8'd0);
    send(CMD_MAP, 8'hAA, 8'h55, 8'h0F);
    send(CMD_BUILD, 8'd0, 8'd0, 8'd0);
    send(CMD_MAP, 8'd255, 8'd255, 8'd255);
    send(CMD_MAP, 8'd0, 8'd0, 8'd0);
    send(CMD_MAP, 8'h55, 8'hAA, 8'hF0);
    // counting after a build, then repeated builds until the sums clip
    send(CMD_COUNT, 8'd1, 8'd2, 8'd3);
    send(CMD_MAP, 8'd1, 8'd2, 8'd3);
    repeat (4) send(CMD_BUILD, 8'hFF, 8'h00, 8'hFF);
    send(CMD_MAP, 8'd255, 8'd255, 8'd255);
    send(CMD_MAP, 8'h80, 8'h40, 8'h20);
    send(CMD_CLEAR, 8'h00, 8'hFF, 8'h00);
    send(CMD_MAP, 8'd255, 8'd255, 8'd255);
    drain();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0)
        set_mode(MODE_GRAY);
      else if (phase == 1)
        set_mode(MODE_RGB);
      else
        set_mode(color_mode_t'($urandom_range(0, 1)));
      sender_quiet = ($urandom_range(0, 3) == 0);
      phase_end    = sent + PHASE_ITEMS;
      while (sent < phase_end && sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 4) != 0)
          run_sequence();
        else
          run_noise();
      end
      drain();
      phase++;
    end

    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Result side: random stalls, quiet stretches, and two long hold-offs while
  // the sender keeps going so the block backs up onto its input
  initial begin
    int unsigned taken;
    int unsigned stall;
    bit          quiet;
    taken = 0;
    quiet = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      stall = quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (taken == 40 || taken == 300) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule

[histogram_equalizer.f]
+incdir+sv
sv/histeq_pkg.sv
sv/histeq_ram.sv
sv/histeq_div.sv
sv/histeq_lane.sv
sv/histogram_equalizer.sv
tb/histeq_tb_pkg.sv
tb/histeq_checker.sv
tb/tb_top.sv
